### sv/sts_pkg.sv
// Shared types, constants and weight function for the spline steering block.
`timescale 1ns / 1ps
package sts_pkg;

  localparam int POINT_COUNT_DEF = 32;
  localparam int CFG_IW = 2;
  localparam int DIV_NW = 38;   // dividend width of the shared divider
  localparam int DUR_W  = 16;
  localparam int WGT_W  = 38;
  localparam int PRD_W  = 58;
  localparam int ACC_W  = 60;
  localparam int ANG_W  = 22;

  localparam logic [CFG_IW-1:0] CFG_CURVE_MODE  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SEG_DUR     = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_TOTAL_DUR   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_START_TIME  = 2'd3;

  localparam logic [4:0]  SEG_MAX     = 5'd31;
  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic signed [ANG_W-1:0] PI_Q      = 22'sd205887;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q = 22'sd102944;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 22'sd411775;
  localparam logic signed [ANG_W-1:0] ANGLE_LIM = 22'sd205888;

  localparam logic [15:0] ATAN_TAB [16] = '{
    16'd51472, 16'd30385, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEG, ST_XDIV, ST_XWAIT, ST_SQ, ST_MAC, ST_SCALE,
    ST_VXDIV, ST_VXWAIT, ST_VZDIV, ST_VZWAIT, ST_POST, ST_PWAIT, ST_EMIT
  } sts_state_e;

  // Derivative basis weight j at normalized time x (Q1.16), xx = x*x.
  function automatic logic signed [WGT_W-1:0] sts_weight(
    input logic mode, input logic [1:0] j, input logic [16:0] x, input logic [32:0] xx);
    logic signed [WGT_W-1:0] o2, ox, sx, t;
    o2 = WGT_W'(64'h1_0000_0000);
    ox = WGT_W'(x) <<< 16;
    sx = WGT_W'(xx);
    t  = '0;
    if (!mode) begin
      case (j)
        2'd0: t = o2 - (ox <<< 1) + sx;
        2'd1: t = sx + (sx <<< 1) - (ox <<< 2) + o2;
        2'd2: t = (ox <<< 1) - sx - (sx <<< 1);
        default: t = sx;
      endcase
      sts_weight = (j == 2'd0) ? -(t + (t <<< 1)) : (t + (t <<< 1));
    end else begin
      case (j)
        2'd0: t = -(o2 - (ox <<< 1) + sx);
        2'd1: t = sx + (sx <<< 1) - (ox <<< 2);
        2'd2: t = o2 + (ox <<< 1) - sx - (sx <<< 1);
        default: t = sx;
      endcase
      sts_weight = t;
    end
  endfunction

endpackage

### sv/sts_point_mem.sv
// Control point table: one write port, one registered read port.
`timescale 1ns / 1ps
module sts_point_mem #(
  parameter int DEPTH = 32,
  parameter int AW = 5,
  parameter int DW = 40
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

### sv/sts_divu.sv
// Unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sts_divu #(
  parameter int NW = 38,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);
  localparam int CW = $clog2(NW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, dv_q;
  logic [DW:0]   rem_sh;
  logic          fit;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign fit    = rem_sh >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fit ? DW'(rem_sh - {1'b0, dv_q}) : rem_sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], fit};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

### sv/sts_vec.sv
// Vector unit: iterative square root for magnitude and CORDIC for the heading angle.
`timescale 1ns / 1ps
module sts_vec
  import sts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic signed [23:0] vx_i,
  input  logic signed [23:0] vz_i,
  output logic              done_o,
  output logic [23:0]       speed_o,
  output logic signed [18:0] angle_o
);
  localparam logic [4:0] LAST = 5'd26;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [47:0] sqx_q, sqz_q;
  logic [49:0] n_q, r_q, bit_q;
  logic signed [35:0] x_q, y_q, xs, ys;
  logic signed [ANG_W-1:0] z_q, base_q, a0, a1;
  logic [3:0]  it;
  logic [49:0] rb;
  logic signed [47:0] pxx, pzz;

  assign pxx = 48'(vx_i) * 48'(vx_i);
  assign pzz = 48'(vz_i) * 48'(vz_i);
  assign it  = 4'(cnt_q - 5'd2);
  assign xs  = x_q >>> it;
  assign ys  = y_q >>> it;
  assign rb  = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (cnt_q == 5'd0) begin
        sqx_q <= pxx;
        sqz_q <= pzz;
        z_q   <= '0;
        if (vx_i < 0) begin
          x_q    <= -(36'(vx_i) <<< 8);
          y_q    <= -(36'(vz_i) <<< 8);
          base_q <= (vz_i >= 0) ? PI_Q : -PI_Q;
        end else begin
          x_q    <= 36'(vx_i) <<< 8;
          y_q    <= 36'(vz_i) <<< 8;
          base_q <= '0;
        end
      end else if (cnt_q == 5'd1) begin
        n_q   <= 50'(sqx_q) + 50'(sqz_q);
        r_q   <= '0;
        bit_q <= 50'd1 << 48;
      end else begin
        if (n_q >= rb) begin
          n_q <= n_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        // Stop rotating once the residual is exactly zero or the arctangent table is used up.
        if (cnt_q <= 5'd17 && y_q != 0) begin
          if (y_q > 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + ANG_W'(ATAN_TAB[it]);
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - ANG_W'(ATAN_TAB[it]);
          end
        end
      end
    end
  end

  // Rotate by -pi/2, wrap into [-pi, pi] and clamp.
  always_comb begin
    a0 = base_q + z_q - HALF_PI_Q;
    if (a0 > PI_Q) a0 = a0 - TWO_PI_Q;
    else if (a0 < -PI_Q) a0 = a0 + TWO_PI_Q;
    a1 = a0;
    if (a0 > ANGLE_LIM) a1 = ANGLE_LIM;
    if (a0 < -ANGLE_LIM) a1 = -ANGLE_LIM;
  end

  assign done_o  = done_q;
  assign speed_o = r_q[23:0];
  assign angle_o = a1[18:0];
endmodule

### sv/spline_trajectory_steer_speed.sv
// Top level: spline trajectory velocity, speed and steering angle engine.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one beat per item: opcode 1 loads a
//    control point (x, z) into the point table, opcode 0 is a time tick at now_ms_i.
//  - Output channel (out_valid_o/out_ready_i) returns exactly one beat per input beat.
//  - Config channel (cfg_valid_i/cfg_ready_o) writes curve mode, segment duration,
//    total duration and start time; write only while no item is in flight.
//  - A load or a finished tick goes straight from idle to the emit state, which loads
//    the output register and returns to idle. A running tick walks the segment
//    step, one division for normalized time, four table reads through the single
//    read port, two velocity divisions and the square root/CORDIC pass; the
//    division for normalized time is skipped when normalized time saturates. The
//    shared divider serves all three divisions at one quotient bit per cycle.
//  - One item is in work at a time; the next input beat is taken once the result
//    moves into the output register, even while that register still waits.
//  - When the receiver stalls, the result holds in the output register and the
//    engine holds its finished result until the register frees.
//  - Reset restores the register defaults, segment 0, start 0 and a held angle of 0.
//    The point table is not cleared; read only entries that were loaded.
module spline_trajectory_steer_speed
  import sts_pkg::*;
#(
  parameter int POINT_COUNT = POINT_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [31:0]         now_ms_i,
  input  logic [4:0]          point_index_i,
  input  logic signed [19:0]  point_x_i,
  input  logic signed [19:0]  point_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [23:0]  vel_x_o,
  output logic signed [23:0]  vel_z_o,
  output logic [23:0]         speed_o,
  output logic signed [18:0]  steer_angle_o,
  output logic                finished_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_IW-1:0]   cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  localparam int AW = $clog2(POINT_COUNT);

  sts_state_e state_q, state_d;

  // Configuration and trajectory state
  logic        mode_q;
  logic [15:0] segdur_q;
  logic [31:0] total_q, start_q, seg_start_q;
  logic [4:0]  seg_num_q;
  logic signed [18:0] held_q;

  // Per-item working registers
  logic [31:0] now_q, d_q;
  logic [16:0] x_q;
  logic [32:0] xx_q;
  logic [2:0]  cnt_q;
  logic signed [PRD_W-1:0] px_q, pz_q;
  logic signed [ACC_W-1:0] accx_q, accz_q;
  logic [DIV_NW-1:0] mx_q, mz_q;
  logic        negx_q, negz_q;
  logic signed [23:0] vx_q, vz_q, res_vx_q, res_vz_q;
  logic [23:0] res_spd_q;
  logic signed [18:0] res_ang_q;
  logic        res_fin_q;

  // Output register
  logic        out_valid_q;
  logic signed [23:0] out_vx_q, out_vz_q;
  logic [23:0] out_spd_q;
  logic signed [18:0] out_ang_q;
  logic        out_fin_q;

  logic [15:0] dur;
  logic        in_fire, cfg_fire, is_fin, out_free;
  logic [31:0] d_now, wr_ext, rd_sum;
  logic        wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [39:0] rd_data;
  logic [1:0]  jw;
  logic [6:0]  rd_base;
  logic signed [WGT_W-1:0] wgt;
  logic signed [PRD_W-1:0] prod_x, prod_z;
  logic [ACC_W-1:0] absx, absz;
  logic [53:0] scx, scz;
  logic [DIV_NW-1:0] div_a, quot;
  logic        div_start, div_busy, div_done;
  logic        vec_start, vec_done;
  logic [23:0] vec_spd;
  logic signed [18:0] vec_ang;
  logic signed [23:0] sat_v;
  logic        sat_neg;

  assign dur      = (segdur_q == '0) ? 16'd1 : segdur_q;
  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign is_fin   = (now_ms_i - start_q) >= total_q;
  assign d_now    = now_q - seg_start_q;
  assign out_free = !out_valid_q || out_ready_i;

  // Point table write on a load beat; indices past the table drop.
  assign wr_ext  = {27'd0, point_index_i};
  assign wr_en   = in_fire && opcode_i && (wr_ext < 32'(POINT_COUNT));
  assign wr_addr = wr_ext[AW-1:0];

  // Read address: stride 3 for Bezier, 1 for B-spline, clamped to the last point.
  assign rd_base = mode_q ? 7'(seg_num_q) : 7'(seg_num_q) * 7'd3;
  assign rd_sum  = 32'(rd_base) + 32'(cnt_q[1:0]);
  assign rd_addr = (rd_sum > 32'(POINT_COUNT - 1)) ? AW'(POINT_COUNT - 1) : rd_sum[AW-1:0];

  sts_point_mem #(.DEPTH(POINT_COUNT), .AW(AW), .DW(40)) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i ({point_x_i, point_z_i}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Multiply the point that returned this cycle by its weight.
  assign jw     = 2'(cnt_q - 3'd1);
  assign wgt    = sts_weight(mode_q, jw, x_q, xx_q);
  assign prod_x = wgt * $signed(rd_data[39:20]);
  assign prod_z = wgt * $signed(rd_data[19:0]);

  // Magnitude scaling: |trunc(S/2^16)| * 1000 / 2^(16+mode), divided by dur after.
  assign absx = accx_q[ACC_W-1] ? ACC_W'(-accx_q) : ACC_W'(accx_q);
  assign absz = accz_q[ACC_W-1] ? ACC_W'(-accz_q) : ACC_W'(accz_q);
  assign scx  = 54'(absx[ACC_W-1:16]) * 54'd1000;
  assign scz  = 54'(absz[ACC_W-1:16]) * 54'd1000;

  always_comb begin
    case (state_q)
      ST_VXDIV: div_a = mx_q;
      ST_VZDIV: div_a = mz_q;
      default:  div_a = {6'd0, d_q[15:0], 16'd0};
    endcase
  end

  sts_divu #(.NW(DIV_NW), .DW(DUR_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (dur),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Saturate the signed velocity to 24 bits.
  assign sat_neg = (state_q == ST_VXWAIT) ? negx_q : negz_q;
  always_comb begin
    if (!sat_neg) begin
      sat_v = (quot > DIV_NW'(24'h7FFFFF)) ? 24'sh7FFFFF : $signed(quot[23:0]);
    end else begin
      sat_v = (quot > DIV_NW'(24'h800000)) ? 24'sh800000 : -$signed(quot[23:0]);
    end
  end

  sts_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (vec_start),
    .vx_i    (vx_q),
    .vz_i    (vz_q),
    .done_o  (vec_done),
    .speed_o (vec_spd),
    .angle_o (vec_ang)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (opcode_i || is_fin) ? ST_EMIT : ST_SEG;
        end
      end
      ST_SEG:    state_d = ST_XDIV;
      ST_XDIV:   state_d = (d_q < 32'(dur)) ? ST_XWAIT : ST_SQ;
      ST_XWAIT:  if (div_done) state_d = ST_SQ;
      ST_SQ:     state_d = ST_MAC;
      ST_MAC:    if (cnt_q == 3'd5) state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_VXDIV;
      ST_VXDIV:  state_d = ST_VXWAIT;
      ST_VXWAIT: if (div_done) state_d = ST_VZDIV;
      ST_VZDIV:  state_d = ST_VZWAIT;
      ST_VZWAIT: if (div_done) state_d = ST_POST;
      ST_POST:   state_d = ST_PWAIT;
      ST_PWAIT:  if (vec_done) state_d = ST_EMIT;
      ST_EMIT:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    vec_start  = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_XDIV:  div_start  = d_q < 32'(dur);
      ST_VXDIV, ST_VZDIV: div_start = 1'b1;
      ST_POST:  vec_start  = 1'b1;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;

  // Control state, configuration and trajectory registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      segdur_q    <= 16'd1000;
      total_q     <= 32'd10000;
      start_q     <= '0;
      seg_start_q <= '0;
      seg_num_q   <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_CURVE_MODE: mode_q   <= cfg_data_i[0];
          CFG_SEG_DUR:    segdur_q <= cfg_data_i[15:0];
          CFG_TOTAL_DUR:  total_q  <= cfg_data_i;
          CFG_START_TIME: begin
            start_q     <= cfg_data_i;
            seg_start_q <= cfg_data_i;
            seg_num_q   <= '0;
          end
          default: ;
        endcase
      end
      // Advance one segment per tick once its time is used up.
      if (state_q == ST_SEG && d_now >= 32'(dur)) begin
        seg_start_q <= seg_start_q + 32'(dur);
        if (seg_num_q < SEG_MAX) seg_num_q <= seg_num_q + 1'b1;
      end
      if (state_q == ST_PWAIT && vec_done) held_q <= vec_ang;
      if (state_q == ST_SQ) cnt_q <= '0;
      else if (state_q == ST_MAC) cnt_q <= cnt_q + 1'b1;
      if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q     <= now_ms_i;
      res_vx_q  <= '0;
      res_vz_q  <= '0;
      res_spd_q <= '0;
      res_ang_q <= held_q;
      res_fin_q <= !opcode_i && is_fin;
    end
    if (state_q == ST_SEG) begin
      d_q <= (d_now >= 32'(dur)) ? d_now - 32'(dur) : d_now;
    end
    if (state_q == ST_XDIV) x_q <= ONE_Q16;
    if (state_q == ST_XWAIT && div_done) x_q <= quot[16:0];
    if (state_q == ST_SQ) begin
      xx_q   <= 33'(34'(x_q) * 34'(x_q));
      accx_q <= '0;
      accz_q <= '0;
    end
    if (state_q == ST_MAC) begin
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
        px_q <= prod_x;
        pz_q <= prod_z;
      end
      if (cnt_q >= 3'd2) begin
        accx_q <= accx_q + ACC_W'(px_q);
        accz_q <= accz_q + ACC_W'(pz_q);
      end
    end
    if (state_q == ST_SCALE) begin
      mx_q   <= mode_q ? DIV_NW'(scx[53:17]) : DIV_NW'(scx[53:16]);
      mz_q   <= mode_q ? DIV_NW'(scz[53:17]) : DIV_NW'(scz[53:16]);
      negx_q <= accx_q[ACC_W-1];
      negz_q <= accz_q[ACC_W-1];
    end
    if (state_q == ST_VXWAIT && div_done) vx_q <= sat_v;
    if (state_q == ST_VZWAIT && div_done) vz_q <= sat_v;
    if (state_q == ST_PWAIT && vec_done) begin
      res_vx_q  <= vx_q;
      res_vz_q  <= vz_q;
      res_spd_q <= vec_spd;
      res_ang_q <= vec_ang;
      res_fin_q <= 1'b0;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_vx_q  <= res_vx_q;
      out_vz_q  <= res_vz_q;
      out_spd_q <= res_spd_q;
      out_ang_q <= res_ang_q;
      out_fin_q <= res_fin_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vel_x_o       = out_vx_q;
  assign vel_z_o       = out_vz_q;
  assign speed_o       = out_spd_q;
  assign steer_angle_o = out_ang_q;
  assign finished_o    = out_fin_q;

`ifndef SYNTH
  a_idle_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("divider busy while taking a new beat");

  a_div_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_XWAIT || state_q == ST_VXWAIT || state_q == ST_VZWAIT))
    else $error("division finished outside a wait state");

  a_fin_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> (speed_o == '0 && vel_x_o == '0 && vel_z_o == '0))
    else $error("finished beat carries motion");

  a_seg_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_fire && cfg_index_i == CFG_START_TIME) |=> seg_num_q >= $past(seg_num_q))
    else $error("segment number stepped back");
`endif
endmodule
